FILE: src/pre_pkg.sv
// shared types and constants for the page replacement engine
package pre_pkg;

    // replacement policy codes
    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_POLICY         = 2'd0;
    localparam logic [1:0] REG_PREPAGE_ENABLE = 2'd1;
    localparam logic [1:0] REG_PAGE_SIZE_LOG2 = 2'd2;
    localparam logic [1:0] REG_FRAMES_IN_USE  = 2'd3;

    // register reset values
    localparam logic [1:0] POLICY_RST         = POL_FIFO;
    localparam logic       PREPAGE_ENABLE_RST = 1'b0;
    localparam logic [3:0] PAGE_SIZE_LOG2_RST = 4'd3;
    localparam logic [6:0] FRAMES_IN_USE_RST  = 7'd64;

    // widths of the configuration port, of result fields and of timestamps
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int OUT_FRAME_W = 6;
    localparam int TIME_W      = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_RST = TIME_W'(1);

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP_RD,
        ST_SWEEP_EV,
        ST_WRITE_V,
        ST_WRITE_P,
        ST_FINISH
    } state_t;

endpackage

FILE: src/pre_ram.sv
// generic simple dual-port ram with registered read
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/page_replacement_engine.sv
// page replacement engine: frame table, victim selection and prepaging
//
// Usage: one access address is taken per transfer on the s_ channel; one
// result (hit flag, frame, prefetch flag and frame) leaves on the m_ channel
// for every address. Policy, prepaging, page size and frame count sit in
// an APB register file. The user must change them only while the block is
// idle; the block itself does not enforce this. The frame table (page,
// timestamp, reference bit per frame) lives in one ram with one write and
// one registered read port; a small sequencer walks it one frame per cycle
// and a single compare path does the page match and the oldest-timestamp
// search in the same pass. With n managed frames the scan reads each of
// the n frames in turn. A fifo or lru fault adds a victim write, and a
// prepage write with prepaging; a clock fault adds those and a read and an
// evaluate step per frame the hand inspects, at most n+1 frames. s_ready
// is high only while the sequencer idles. After reset a clearing pass
// writes zero to all FRAMES entries, one per cycle, and s_ready stays low
// until that pass is done.
// A finished result waits in the output register while the receiver
// stalls; the next address can still be taken, and its result is held back
// until the output register is free.
module page_replacement_engine #(
    parameter int FRAMES    = 64,
    parameter int ADDR_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pre_pkg::PADDR_W-1:0]     paddr,
    input  logic [pre_pkg::PDATA_W-1:0]     pwdata,
    output logic [pre_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    // access channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ADDR_BITS-1:0]            s_address,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [pre_pkg::OUT_FRAME_W-1:0] m_frame_index,
    output logic                            m_prefetch_valid,
    output logic [pre_pkg::OUT_FRAME_W-1:0] m_prefetch_frame
);

    import pre_pkg::*;

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int N_W    = $clog2(FRAMES + 1);
    localparam int NB_W   = (N_W > 7) ? N_W : 7;
    localparam int WORD_W = 1 + TIME_W + ADDR_BITS;
    localparam int PAGE_LO = 0;
    localparam int TIME_LO = ADDR_BITS;
    localparam int REF_BIT = WORD_W - 1;

    // configuration registers
    logic [1:0] policy_reg;
    logic       prepage_enable_reg;
    logic [3:0] page_size_log2_reg;
    logic [6:0] frames_in_use_reg;

    // sequencer and datapath registers
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [ADDR_BITS-1:0]  page_reg, page_next;
    logic [N_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]      ev_idx_reg, ev_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      vic_idx_reg, vic_idx_next;
    logic [TIME_W-1:0]     vic_time_reg, vic_time_next;
    logic                  vic_ref_reg, vic_ref_next;
    logic                  pf_valid_reg, pf_valid_next;
    logic [IDX_W-1:0]      pf_idx_reg, pf_idx_next;
    logic [IDX_W-1:0]      hand_reg, hand_next;
    logic [TIME_W-1:0]     access_time_reg, access_time_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic                   m_hit_reg, m_hit_next;
    logic [OUT_FRAME_W-1:0] m_frame_reg, m_frame_next;
    logic                   m_pf_valid_reg, m_pf_valid_next;
    logic [OUT_FRAME_W-1:0] m_pf_frame_reg, m_pf_frame_next;

    // ram controls
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // decoded values
    logic [NB_W-1:0]      fiu_ext;
    logic [NB_W-1:0]      n_big;
    logic [N_W-1:0]       n_act;
    logic                 is_lru;
    logic                 is_clock;
    logic                 do_prepage;
    logic                 s_xfer;
    logic                 m_xfer;
    logic                 out_free;
    logic                 scan_done;
    logic                 page_match;
    logic [ADDR_BITS-1:0] rd_page;
    logic [TIME_W-1:0]    rd_time;
    logic                 rd_ref;
    logic                 cfg_wr;

    // next frame, cyclic over the managed frames
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] k,
                                                  input logic [N_W-1:0] nn);
        logic [N_W-1:0] k1;
        k1 = N_W'(k) + N_W'(1);
        return (k1 >= nn) ? '0 : k1[IDX_W-1:0];
    endfunction

    pre_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // managed frame count, clamped to one..FRAMES
    assign fiu_ext = NB_W'(frames_in_use_reg);
    assign n_big   = (fiu_ext == '0) ? NB_W'(1)
                   : (fiu_ext > NB_W'(FRAMES)) ? NB_W'(FRAMES) : fiu_ext;
    assign n_act   = n_big[N_W-1:0];

    assign is_lru     = (policy_reg == POL_LRU);
    assign is_clock   = (policy_reg == POL_CLOCK);
    assign do_prepage = prepage_enable_reg && (n_act != N_W'(1));

    assign rd_page    = ram_rdata[PAGE_LO +: ADDR_BITS];
    assign rd_time    = ram_rdata[TIME_LO +: TIME_W];
    assign rd_ref     = ram_rdata[REF_BIT];
    assign page_match = (rd_page == page_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = (scan_idx_reg == n_act) && !ev_valid_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg         <= POLICY_RST;
            prepage_enable_reg <= PREPAGE_ENABLE_RST;
            page_size_log2_reg <= PAGE_SIZE_LOG2_RST;
            frames_in_use_reg  <= FRAMES_IN_USE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_POLICY:         policy_reg         <= pwdata[1:0];
                REG_PREPAGE_ENABLE: prepage_enable_reg <= pwdata[0];
                REG_PAGE_SIZE_LOG2: page_size_log2_reg <= pwdata[3:0];
                REG_FRAMES_IN_USE:  frames_in_use_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_POLICY:         prdata = PDATA_W'(policy_reg);
            REG_PREPAGE_ENABLE: prdata = PDATA_W'(prepage_enable_reg);
            REG_PAGE_SIZE_LOG2: prdata = PDATA_W'(page_size_log2_reg);
            REG_FRAMES_IN_USE:  prdata = PDATA_W'(frames_in_use_reg);
            default:            prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == IDX_W'(FRAMES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    if (found_reg) begin
                        state_next = ST_FINISH;
                    end else if (is_clock) begin
                        state_next = ST_SWEEP_RD;
                    end else begin
                        state_next = ST_WRITE_V;
                    end
                end
            end
            ST_SWEEP_RD: state_next = ST_SWEEP_EV;
            ST_SWEEP_EV: begin
                state_next = rd_ref ? ST_SWEEP_RD : ST_WRITE_V;
            end
            ST_WRITE_V: begin
                state_next = do_prepage ? ST_WRITE_P : ST_FINISH;
            end
            ST_WRITE_P: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ram controls per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
            end
            ST_SCAN: begin
                // issue the next read; under lru or clock, refresh a matching frame from the last one
                ram_re    = (scan_idx_reg < n_act);
                ram_raddr = scan_idx_reg[IDX_W-1:0];
                if (ev_valid_reg && page_match && (is_lru || is_clock)) begin
                    ram_we    = 1'b1;
                    ram_waddr = ev_idx_reg;
                    ram_wdata = is_lru ? {rd_ref, access_time_reg, rd_page}
                                       : {1'b1, rd_time, rd_page};
                end
            end
            ST_SWEEP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = vic_idx_reg;
            end
            ST_SWEEP_EV: begin
                // second chance: clear the reference bit and move on
                if (rd_ref) begin
                    ram_we    = 1'b1;
                    ram_waddr = vic_idx_reg;
                    ram_wdata = {1'b0, rd_time, rd_page};
                end
            end
            ST_WRITE_V: begin
                ram_we    = 1'b1;
                ram_waddr = vic_idx_reg;
                ram_wdata = is_clock ? {1'b1, vic_time_reg, page_reg}
                                     : {vic_ref_reg, access_time_reg, page_reg};
            end
            ST_WRITE_P: begin
                ram_we    = 1'b1;
                ram_waddr = pf_idx_reg;
                ram_wdata = {1'b1, access_time_reg, ADDR_BITS'(page_reg + 1'b1)};
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        clr_idx_next     = clr_idx_reg;
        page_next        = page_reg;
        scan_idx_next    = scan_idx_reg;
        ev_valid_next    = 1'b0;
        ev_idx_next      = ev_idx_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        vic_idx_next     = vic_idx_reg;
        vic_time_next    = vic_time_reg;
        vic_ref_next     = vic_ref_reg;
        pf_valid_next    = pf_valid_reg;
        pf_idx_next      = pf_idx_reg;
        hand_next        = hand_reg;
        access_time_next = access_time_reg;
        m_valid_next     = m_xfer ? 1'b0 : m_valid_reg;
        m_hit_next       = m_hit_reg;
        m_frame_next     = m_frame_reg;
        m_pf_valid_next  = m_pf_valid_reg;
        m_pf_frame_next  = m_pf_frame_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    page_next     = s_address >> page_size_log2_reg;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    pf_valid_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg < n_act) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    ev_valid_next = 1'b1;
                    ev_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                if (ev_valid_reg) begin
                    // page match, last matching frame wins
                    if (page_match) begin
                        found_next   = 1'b1;
                        hit_idx_next = ev_idx_reg;
                    end
                    // oldest timestamp, lowest index on a tie
                    if (ev_idx_reg == '0 || rd_time < vic_time_reg) begin
                        vic_idx_next  = ev_idx_reg;
                        vic_time_next = rd_time;
                        vic_ref_next  = rd_ref;
                    end
                end
                if (scan_done && !found_reg && is_clock) begin
                    vic_idx_next = (N_W'(hand_reg) < n_act) ? hand_reg : '0;
                end
            end
            ST_SWEEP_EV: begin
                if (rd_ref) begin
                    vic_idx_next = next_idx(vic_idx_reg, n_act);
                end else begin
                    vic_time_next = rd_time;
                    vic_ref_next  = rd_ref;
                end
            end
            ST_WRITE_V: begin
                pf_idx_next = next_idx(vic_idx_reg, n_act);
                if (!do_prepage) begin
                    hand_next = next_idx(vic_idx_reg, n_act);
                end
            end
            ST_WRITE_P: begin
                pf_valid_next = 1'b1;
                hand_next     = next_idx(pf_idx_reg, n_act);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_hit_next      = found_reg;
                    m_frame_next    = OUT_FRAME_W'(found_reg ? hit_idx_reg : vic_idx_reg);
                    m_pf_valid_next = pf_valid_reg;
                    m_pf_frame_next = pf_valid_reg ? OUT_FRAME_W'(pf_idx_reg) : '0;
                    if (access_time_reg != TIME_MAX) begin
                        access_time_next = access_time_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            ev_valid_reg    <= 1'b0;
            hand_reg        <= '0;
            access_time_reg <= TIME_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            ev_valid_reg    <= ev_valid_next;
            hand_reg        <= hand_next;
            access_time_reg <= access_time_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        page_reg       <= page_next;
        scan_idx_reg   <= scan_idx_next;
        ev_idx_reg     <= ev_idx_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        vic_idx_reg    <= vic_idx_next;
        vic_time_reg   <= vic_time_next;
        vic_ref_reg    <= vic_ref_next;
        pf_valid_reg   <= pf_valid_next;
        pf_idx_reg     <= pf_idx_next;
        m_hit_reg      <= m_hit_next;
        m_frame_reg    <= m_frame_next;
        m_pf_valid_reg <= m_pf_valid_next;
        m_pf_frame_reg <= m_pf_frame_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_frame_index    = m_frame_reg;
    assign m_prefetch_valid = m_pf_valid_reg;
    assign m_prefetch_frame = m_pf_frame_reg;

    // table writes stay inside the managed frames once the clear is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != ST_CLEAR) |-> (N_W'(ram_waddr) < n_act))
        else $error("frame table write outside managed frames");

    // a hit never reports a prepaged frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> !m_prefetch_valid)
        else $error("prefetch reported on a hit");

    // an accepted address starts a table scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == ST_SCAN && scan_idx_reg == '0))
        else $error("accepted address did not start a scan");

    // the access counter never moves backward
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (access_time_reg >= $past(access_time_reg)))
        else $error("access counter moved backward");

endmodule
